### sv/ipv4_fragment_reassembly_tracker_defines.svh
// Assertion helpers for the fragment reassembly tracker
`ifndef IPV4_FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH
`define IPV4_FRAGMENT_REASSEMBLY_TRACKER_DEFINES_SVH

`define IFR_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");

`define IFR_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/ifr_pkg.sv
package ifr_pkg;

  typedef struct packed {
    logic        mode;
    logic [15:0] ip_ident;
    logic [7:0]  protocol_num;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [12:0] frag_offset;
    logic        more_frags;
    logic [15:0] total_len;
    logic [3:0]  hdr_words;
    logic [15:0] buffer_tag;
  } ifr_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_tag;
    logic [5:0]  strip_bytes;
    logic [15:0] new_total_len;
    logic        last;
  } ifr_out_t;

  // slot word: offset, payload length, MF, header words, tag
  typedef struct packed {
    logic [12:0] offset;
    logic [15:0] paylen;
    logic        more;
    logic [3:0]  hdr_words;
    logic [15:0] tag;
  } ifr_slot_t;

  localparam int SlotW = $bits(ifr_slot_t);

  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_NO_CTX  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

endpackage

### sv/ipv4_fragment_reassembly_tracker.sv
// Throughput: one item at a time, in_stall is high while busy. A tick visits
// every context once. A fragment with a drop result leaves after the context
// scan; a stored fragment is shifted into place and walked for contiguity
// before its pending result, and a completed packet gives one result per
// fragment in offset order. Every result also waits on out_stall. Shift and
// contiguity walk share the one read port of the slot RAM.
// Reset (rst_n low, synchronous) clears all contexts and sets timeout to 60.
module ipv4_fragment_reassembly_tracker #(
  parameter int NUM_CONTEXTS      = 8,
  parameter int FRAGS_PER_CONTEXT = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ifr_pkg::ifr_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ifr_pkg::ifr_out_t out_data,
  input  logic             cfg_we,
  input  logic [15:0]      cfg_wdata
);
  import ifr_pkg::*;
  `include "ipv4_fragment_reassembly_tracker_defines.svh"

  localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int NW = $clog2(FRAGS_PER_CONTEXT + 1);
  localparam int CCW = $clog2(NUM_CONTEXTS + 1);
  localparam int SD = NUM_CONTEXTS * FRAGS_PER_CONTEXT;
  localparam int SAW = $clog2(SD) > 0 ? $clog2(SD) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TICK  = 4'd1;
  localparam logic [3:0] S_MATCH = 4'd2;
  localparam logic [3:0] S_FREE  = 4'd3;
  localparam logic [3:0] S_SHRD  = 4'd4;
  localparam logic [3:0] S_SHWT  = 4'd5;
  localparam logic [3:0] S_SHWR  = 4'd6;
  localparam logic [3:0] S_INS   = 4'd7;
  localparam logic [3:0] S_CKRD  = 4'd8;
  localparam logic [3:0] S_CKWT  = 4'd9;
  localparam logic [3:0] S_CKEV  = 4'd10;
  localparam logic [3:0] S_EMRD  = 4'd11;
  localparam logic [3:0] S_EMWT  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [3:0]  state_r, state_nxt;
  logic [15:0] timeout_r;
  ifr_in_t     item_r;
  logic [NUM_CONTEXTS-1:0] vld_r;
  logic [63:0] pair_r [NUM_CONTEXTS];
  logic [23:0] key_r  [NUM_CONTEXTS];
  logic [15:0] age_r  [NUM_CONTEXTS];
  logic [NW-1:0] cnt_r [NUM_CONTEXTS];
  logic [CCW-1:0] ci_r;
  logic [CW-1:0]  ctx_r;
  logic [NW-1:0]  i_r, pos_r, n_r;
  // one bit wider so a run past 64K never matches a later offset
  logic [16:0]    exp_r;
  logic [15:0]    tl_r;
  logic           emit_r, done_r;
  ifr_out_t       res_r;

  logic           we;
  logic [SAW-1:0] waddr, raddr;
  ifr_slot_t      wslot, rslot;
  logic [SlotW-1:0] rbits;

  ifr_ram #(.Width(SlotW), .Depth(SD)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wslot), .raddr(raddr), .rdata(rbits)
  );
  assign rslot = ifr_slot_t'(rbits);

  function automatic logic [SAW-1:0] saddr(logic [CW-1:0] c, logic [NW-1:0] i);
    logic [31:0] a;
    a = 32'(c) * 32'(FRAGS_PER_CONTEXT) + 32'(i);
    return a[SAW-1:0];
  endfunction

  logic [CW-1:0] cs;
  assign cs = ci_r[CW-1:0];
  logic [15:0] agei;
  assign agei = (age_r[cs] == 16'hFFFF) ? age_r[cs] : age_r[cs] + 16'd1;
  logic [15:0] o8;
  assign o8 = {rslot.offset[12:0], 3'b000};

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  always_comb begin
    we = 1'b0; waddr = saddr(ctx_r, i_r); raddr = saddr(ctx_r, i_r);
    wslot = rslot;
    // keep the entry below i on the read port until it is written up
    if (state_r == S_SHRD || state_r == S_SHWT) raddr = saddr(ctx_r, i_r - NW'(1));
    if (state_r == S_SHWR) we = 1'b1;
    if (state_r == S_INS) begin
      we = 1'b1;
      waddr = saddr(ctx_r, pos_r);
      wslot.offset = item_r.frag_offset;
      wslot.paylen = item_r.total_len - {10'd0, item_r.hdr_words, 2'b00};
      wslot.more = item_r.more_frags;
      wslot.hdr_words = item_r.hdr_words;
      wslot.tag = item_r.buffer_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      timeout_r <= 16'd60;
      vld_r <= '0;
    end else begin
      if (cfg_we) timeout_r <= cfg_wdata;
      case (state_r)
        S_IDLE: if (in_valid) begin
          item_r <= in_data;
          ci_r <= '0;
          state_r <= in_data.mode ? S_TICK : S_MATCH;
        end
        S_TICK: begin
          if (vld_r[cs]) begin
            age_r[cs] <= agei;
            if (agei >= timeout_r) vld_r[cs] <= 1'b0;
          end
          ci_r <= ci_r + CCW'(1);
          if (ci_r == CCW'(NUM_CONTEXTS - 1)) state_r <= S_IDLE;
        end
        S_MATCH: begin
          if (vld_r[cs] && pair_r[cs] == {item_r.src_addr, item_r.dst_addr} &&
              key_r[cs] == {item_r.ip_ident, item_r.protocol_num}) begin
            ctx_r <= cs;
            n_r <= cnt_r[cs];
            if (cnt_r[cs] >= NW'(FRAGS_PER_CONTEXT)) begin
              res_r <= '{ST_FULL, item_r.buffer_tag, 6'd0, 16'd0, 1'b1};
              done_r <= 1'b1; state_r <= S_OUT;
            end else begin
              i_r <= cnt_r[cs]; pos_r <= cnt_r[cs];
              state_r <= S_SHRD;
            end
          end else if (ci_r == CCW'(NUM_CONTEXTS - 1)) begin
            ci_r <= '0; state_r <= S_FREE;
          end else ci_r <= ci_r + CCW'(1);
        end
        S_FREE: begin
          if (!vld_r[cs]) begin
            ctx_r <= cs; vld_r[cs] <= 1'b1;
            pair_r[cs] <= {item_r.src_addr, item_r.dst_addr};
            key_r[cs] <= {item_r.ip_ident, item_r.protocol_num};
            age_r[cs] <= '0; cnt_r[cs] <= '0;
            n_r <= '0; i_r <= '0; pos_r <= '0;
            state_r <= S_SHRD;
          end else if (ci_r == CCW'(NUM_CONTEXTS - 1)) begin
            res_r <= '{ST_NO_CTX, item_r.buffer_tag, 6'd0, 16'd0, 1'b1};
            done_r <= 1'b1; state_r <= S_OUT;
          end else ci_r <= ci_r + CCW'(1);
        end
        // walk down from the tail, shifting entries with offset > new
        S_SHRD: state_r <= (i_r == '0) ? S_INS : S_SHWT;
        S_SHWT: state_r <= (rslot.offset > item_r.frag_offset) ? S_SHWR : S_INS;
        S_SHWR: begin
          i_r <= i_r - NW'(1); pos_r <= i_r - NW'(1);
          state_r <= S_SHRD;
        end
        S_INS: begin
          cnt_r[ctx_r] <= n_r + NW'(1);
          n_r <= n_r + NW'(1);
          i_r <= '0; exp_r <= '0;
          state_r <= S_CKRD;
        end
        S_CKRD: state_r <= S_CKWT;
        S_CKWT: state_r <= S_CKEV;
        S_CKEV: begin
          if ({1'b0, o8} != exp_r || (i_r == n_r - NW'(1) && rslot.more)) begin
            res_r <= '{ST_PENDING, item_r.buffer_tag, 6'd0, 16'd0, 1'b1};
            done_r <= 1'b1; state_r <= S_OUT;
          end else if (i_r == n_r - NW'(1)) begin
            tl_r <= o8 + rslot.paylen;
            i_r <= '0; state_r <= S_EMRD;
          end else begin
            exp_r <= {1'b0, o8} + {1'b0, rslot.paylen};
            i_r <= i_r + NW'(1); state_r <= S_CKRD;
          end
        end
        S_EMRD: state_r <= S_EMWT;
        S_EMWT: begin
          res_r.status <= ST_DONE;
          res_r.out_tag <= rslot.tag;
          res_r.last <= (i_r == n_r - NW'(1));
          done_r <= (i_r == n_r - NW'(1));
          if (i_r == '0) begin
            res_r.strip_bytes <= 6'd0;
            res_r.new_total_len <= tl_r + {10'd0, rslot.hdr_words, 2'b00};
          end else begin
            res_r.strip_bytes <= {rslot.hdr_words, 2'b00};
            res_r.new_total_len <= 16'd0;
          end
          if (i_r == n_r - NW'(1)) vld_r[ctx_r] <= 1'b0;
          state_r <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          if (done_r) state_r <= S_IDLE;
          else begin
            i_r <= i_r + NW'(1); state_r <= S_EMRD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `IFR_ASSERT_IMP(a_busy_no_accept, state_r != S_IDLE, in_stall)
  `IFR_ASSERT_IMP(a_out_last_done, out_valid && res_r.status != ST_DONE, res_r.last)
  `IFR_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(res_r))
  `IFR_ASSERT_IMP(a_first_strip, out_valid && res_r.new_total_len != 16'd0,
                  res_r.strip_bytes == 6'd0)
endmodule

### sv/ifr_ram.sv
module ifr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
